// ===== sv/assert_macros.svh =====
// Assertion macros shared by the median filter RTL.
// Both macros use clock from the including module; MF3_ASSERT also reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define MF3_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MF3_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/mf3_pkg.sv =====
// Shared types and constants for the 3x3 median filter.
// No dependencies; used by all mf3_* modules and the top level.
`timescale 1ns / 1ps

package mf3_pkg;

   localparam int PIXEL_W       = 8;
   localparam int ROW_W         = 13;
   localparam int FRAME_WIDTH_W = 11;
   localparam int CSR_DATA_W    = 13;
   localparam int CSR_INDEX_W   = 2;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // Input item kinds
   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   localparam int MIN_SIZE           = 3;
   localparam int MAX_HEIGHT         = 4096;
   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   localparam int QUEUE_DEPTH = 4;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // Per-item control carried from the front to the back
   typedef struct packed {
      logic emit;      // item completes a center
      logic top_ok;    // row above the center is inside the image
      logic bot_ok;    // row below the center is inside the image
      logic left_ok;   // column left of the center is inside the image
      logic right_ok;  // column right of the center is inside the image
      logic last;      // final center of the frame
   } mf3_flags_type;

endpackage

// ===== sv/mf3_front.sv =====
// Front end of the median filter: frame geometry registers, raster counters
// and per-item classification. Depends on mf3_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mf3_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write,
   input  logic [mf3_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]          csr_data,
   input  logic                                    accept,
   input  logic                                    action,
   input  mf3_pkg::pixel_type                      pixel,
   output logic                                    push_valid,
   output mf3_pkg::pixel_type                      push_pixel,
   output logic [$clog2(MAX_WIDTH)-1:0]            push_addr,
   output mf3_pkg::mf3_flags_type                  push_flags
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = mf3_pkg::ROW_W;
   localparam int unsigned WIDTH_RST =
      (mf3_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : mf3_pkg::FRAME_WIDTH_RESET;
   localparam int unsigned HEIGHT_RST = mf3_pkg::FRAME_HEIGHT_RESET;

   logic [AW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [WW-1:0] wm1_ff, wm1_in;   // effective width - 1
   logic [RW-1:0] hm1_ff, hm1_in;   // effective height - 1

   logic          is_flush;
   logic          ignore;
   logic          col_zero;
   logic          row_wrap;
   logic [RW-1:0] center_row;
   logic [WW-1:0] center_col;
   logic [31:0]   width_ext;
   logic [31:0]   height_ext;
   logic [31:0]   width_m1;
   logic [31:0]   height_m1;
   mf3_pkg::mf3_flags_type flags;

   always_comb begin
      is_flush = (action == mf3_pkg::ACTION_FLUSH);
      col_zero = (col_ff == '0);
      ignore   = is_flush && col_zero && (row_ff == '0);
      row_wrap = (WW'(col_ff) == wm1_ff);

      // Flushes and anything past the frame's last row shift in zero.
      push_pixel = (is_flush || (row_ff > hm1_ff)) ? '0 : pixel;
      push_addr  = col_ff;

      // At column zero the completed center is the end of the row before last.
      if (col_zero) begin
         center_row = row_ff - RW'(2);
         center_col = wm1_ff;
      end else begin
         center_row = row_ff - RW'(1);
         center_col = WW'(col_ff) - WW'(1);
      end

      flags.emit     = (row_ff >= RW'(2)) || ((row_ff == RW'(1)) && !col_zero);
      flags.top_ok   = (center_row != '0);
      flags.bot_ok   = (center_row != hm1_ff);
      flags.left_ok  = (center_col != '0);
      flags.right_ok = (center_col != wm1_ff);
      flags.last     = flags.emit && !flags.bot_ok && !flags.right_ok;

      push_flags = flags;
      push_valid = accept && !ignore;
   end

   // Geometry clamping and counter update
   always_comb begin
      width_ext  = 32'(csr_data[mf3_pkg::FRAME_WIDTH_W-1:0]);
      height_ext = 32'(csr_data);

      if (width_ext < 32'(mf3_pkg::MIN_SIZE)) begin
         width_m1 = 32'(mf3_pkg::MIN_SIZE - 1);
      end else if (width_ext > 32'(MAX_WIDTH)) begin
         width_m1 = 32'(MAX_WIDTH - 1);
      end else begin
         width_m1 = width_ext - 32'd1;
      end

      if (height_ext < 32'(mf3_pkg::MIN_SIZE)) begin
         height_m1 = 32'(mf3_pkg::MIN_SIZE - 1);
      end else if (height_ext > 32'(mf3_pkg::MAX_HEIGHT)) begin
         height_m1 = 32'(mf3_pkg::MAX_HEIGHT - 1);
      end else begin
         height_m1 = height_ext - 32'd1;
      end

      wm1_in = wm1_ff;
      hm1_in = hm1_ff;
      col_in = col_ff;
      row_in = row_ff;

      if (csr_write && (csr_index == mf3_pkg::CSR_FRAME_WIDTH ||
                        csr_index == mf3_pkg::CSR_FRAME_HEIGHT)) begin
         if (csr_index == mf3_pkg::CSR_FRAME_WIDTH) begin
            wm1_in = width_m1[WW-1:0];
         end else begin
            hm1_in = height_m1[RW-1:0];
         end
         col_in = '0;
         row_in = '0;
      end else if (push_valid) begin
         if (flags.last) begin
            col_in = '0;
            row_in = '0;
         end else if (row_wrap) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         wm1_ff <= WW'(WIDTH_RST - 1);
         hm1_ff <= RW'(HEIGHT_RST - 1);
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         wm1_ff <= wm1_in;
         hm1_ff <= hm1_in;
      end
   end

   `MF3_ASSERT(a_fe_col_range, WW'(col_ff) <= wm1_ff, "column counter past row end")
   `MF3_ASSERT(a_fe_restart,
      (push_valid && flags.last && !csr_write) |=> (col_ff == '0 && row_ff == '0),
      "frame did not restart after last center")

endmodule

// ===== sv/mf3_queue.sv =====
// Small FIFO between the front and back halves of the median filter.
// Depends on mf3_pkg for its depth and on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mf3_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);

   localparam int DEPTH = mf3_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   always_comb begin
      full      = (count_ff == CW'(DEPTH));
      pop_valid = (count_ff != '0);
      pop_data  = entry_ff[rd_ptr_ff];

      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `MF3_ASSERT(a_q_no_overflow, push |-> (count_ff < CW'(DEPTH) || pop), "push into a full queue")
   `MF3_ASSERT(a_q_no_underflow, pop |-> (count_ff != '0), "pop from an empty queue")

endmodule

// ===== sv/mf3_back.sv =====
// Back end of the median filter: line store memory, 3x3 window, border
// masking and a three-stage median network with the output register.
// Depends on mf3_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mf3_back #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  mf3_pkg::pixel_type            q_pixel,
   input  logic [$clog2(MAX_WIDTH)-1:0]  q_addr,
   input  mf3_pkg::mf3_flags_type        q_flags,
   output logic                          q_pop,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output mf3_pkg::pixel_type            rsp_median,
   output logic                          rsp_last
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int PW = mf3_pkg::PIXEL_W;

   function automatic mf3_pkg::pixel_type min2(input mf3_pkg::pixel_type a,
                                               input mf3_pkg::pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic mf3_pkg::pixel_type max2(input mf3_pkg::pixel_type a,
                                               input mf3_pkg::pixel_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic mf3_pkg::pixel_type med3(input mf3_pkg::pixel_type a,
                                               input mf3_pkg::pixel_type b,
                                               input mf3_pkg::pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // Line store: [2*PW-1:PW] is the row two up, [PW-1:0] the row above
   logic [2*PW-1:0] ls_mem [MAX_WIDTH];

   logic                   adv;
   logic                   b1_valid_ff;
   logic [2*PW-1:0]        rd_ff;
   mf3_pkg::pixel_type     b1_pixel_ff;
   logic [AW-1:0]          b1_addr_ff;
   mf3_pkg::mf3_flags_type b1_flags_ff;

   logic                   b2_valid_ff;
   mf3_pkg::mf3_flags_type b2_flags_ff;
   logic [2:0][2:0][PW-1:0] window_ff;   // [row][col], row 0 on top

   logic                   s1_valid_ff;
   logic                   s1_last_ff;
   logic [2:0][PW-1:0]     s1_lo_ff, s1_md_ff, s1_hi_ff;
   logic [2:0][PW-1:0]     s1_lo_in, s1_md_in, s1_hi_in;
   logic [2:0][2:0][PW-1:0] nb;
   logic [2:0]             row_ok, col_ok;

   logic                   s2_valid_ff;
   logic                   s2_last_ff;
   mf3_pkg::pixel_type     s2_lo_ff, s2_md_ff, s2_hi_ff;
   mf3_pkg::pixel_type     s2_lo_in, s2_md_in, s2_hi_in;

   logic                   rsp_valid_ff;
   logic                   rsp_last_ff;
   mf3_pkg::pixel_type     rsp_median_ff, rsp_median_in;

   // Whole back end moves together whenever the output register can take data
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = adv && q_valid;

   // Mask out-of-image neighbors, then sort each window row
   always_comb begin
      row_ok = {b2_flags_ff.bot_ok, 1'b1, b2_flags_ff.top_ok};
      col_ok = {b2_flags_ff.right_ok, 1'b1, b2_flags_ff.left_ok};
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            nb[i][j] = (row_ok[i] && col_ok[j]) ? window_ff[i][j] : '0;
         end
         s1_lo_in[i] = min2(min2(nb[i][0], nb[i][1]), nb[i][2]);
         s1_md_in[i] = med3(nb[i][0], nb[i][1], nb[i][2]);
         s1_hi_in[i] = max2(max2(nb[i][0], nb[i][1]), nb[i][2]);
      end
   end

   // Largest low, middle of middles, smallest high; their median is the answer
   always_comb begin
      s2_lo_in      = max2(max2(s1_lo_ff[0], s1_lo_ff[1]), s1_lo_ff[2]);
      s2_md_in      = med3(s1_md_ff[0], s1_md_ff[1], s1_md_ff[2]);
      s2_hi_in      = min2(min2(s1_hi_ff[0], s1_hi_ff[1]), s1_hi_ff[2]);
      rsp_median_in = med3(s2_lo_ff, s2_md_ff, s2_hi_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff  <= q_valid;
         b2_valid_ff  <= b1_valid_ff && b1_flags_ff.emit;
         s1_valid_ff  <= b2_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // Line store: registered read at the queue head, write one stage later
   always_ff @(posedge clock) begin
      if (adv && q_valid) begin
         rd_ff <= ls_mem[q_addr];
      end
      if (adv && b1_valid_ff) begin
         ls_mem[b1_addr_ff] <= {rd_ff[PW-1:0], b1_pixel_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_pixel_ff <= q_pixel;
         b1_addr_ff  <= q_addr;
         b1_flags_ff <= q_flags;
         b2_flags_ff <= b1_flags_ff;
         if (b1_valid_ff) begin
            for (int i = 0; i < 3; i++) begin
               window_ff[i][0] <= window_ff[i][1];
               window_ff[i][1] <= window_ff[i][2];
            end
            window_ff[0][2] <= rd_ff[2*PW-1:PW];
            window_ff[1][2] <= rd_ff[PW-1:0];
            window_ff[2][2] <= b1_pixel_ff;
         end
         s1_lo_ff      <= s1_lo_in;
         s1_md_ff      <= s1_md_in;
         s1_hi_ff      <= s1_hi_in;
         s1_last_ff    <= b2_flags_ff.last;
         s2_lo_ff      <= s2_lo_in;
         s2_md_ff      <= s2_md_in;
         s2_hi_ff      <= s2_hi_in;
         s2_last_ff    <= s1_last_ff;
         rsp_median_ff <= rsp_median_in;
         rsp_last_ff   <= s2_last_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;
   assign rsp_last   = rsp_last_ff;

   `MF3_ASSERT(a_bk_window_hold, !adv |=> $stable(window_ff), "window moved during a stall")

endmodule

// ===== sv/median_filter_3x3.sv =====
// Top level of the streaming 3x3 median filter.
// Depends on mf3_pkg, mf3_front, mf3_queue and mf3_back.
//
//   port group  direction  handshake            payload
//   req_*       in         req_valid/req_stall  req_action, req_pixel
//   rsp_*       out        rsp_valid/rsp_stall  rsp_median, rsp_last
//   csr_*       in         csr_valid/csr_ready  csr_index, csr_data
//
// One item per clock when not stalled; the front classifies in the cycle of the transfer.
// A result moves from the queue through b1, window, s1 and s2 into the output register.
// The line store is one memory read at the queue head and written from the b1 stage.
// rsp_stall freezes the back end; the four-entry queue then fills and raises req_stall.
// Reset is synchronous; geometry returns to 640x480, line store contents are not cleared.
`timescale 1ns / 1ps

module median_filter_3x3 #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  mf3_pkg::pixel_type                 req_pixel,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mf3_pkg::pixel_type                 rsp_median,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mf3_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int AW     = $clog2(MAX_WIDTH);
   localparam int FW     = $bits(mf3_pkg::mf3_flags_type);
   localparam int PW     = mf3_pkg::PIXEL_W;
   localparam int DATA_W = PW + AW + FW;

   logic                   req_accept;
   logic                   csr_write;
   logic                   push_valid;
   mf3_pkg::pixel_type     push_pixel;
   logic [AW-1:0]          push_addr;
   mf3_pkg::mf3_flags_type push_flags;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_valid;
   logic [DATA_W-1:0]      q_data;
   mf3_pkg::pixel_type     q_pixel;
   logic [AW-1:0]          q_addr;
   mf3_pkg::mf3_flags_type q_flags;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   assign q_pixel = q_data[DATA_W-1 -: PW];
   assign q_addr  = q_data[FW +: AW];
   assign q_flags = q_data[FW-1:0];

   mf3_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .accept     (req_accept),
      .action     (req_action),
      .pixel      (req_pixel),
      .push_valid (push_valid),
      .push_pixel (push_pixel),
      .push_addr  (push_addr),
      .push_flags (push_flags)
   );

   mf3_queue #(
      .DATA_W(DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_pixel, push_addr, push_flags}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   mf3_back #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pixel    (q_pixel),
      .q_addr     (q_addr),
      .q_flags    (q_flags),
      .q_pop      (q_pop),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_median (rsp_median),
      .rsp_last   (rsp_last)
   );

endmodule

// ===== sim/tb_median_filter_3x3.sv =====
// Self-checking testbench for median_filter_3x3: drives pixel frames and register writes,
// predicts every median in a behavioral filter and checks each result transfer.
// Depends on mf3_pkg and the median_filter_3x3 RTL.
`timescale 1ns / 1ps

module tb_median_filter_3x3;

   localparam int LINE_DEPTH     = 1024;
   localparam int MAX_GAP        = 14;
   localparam int LONG_HOLD      = 300;
   localparam int LATENCY_CYCLES = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 120;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [mf3_pkg::CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd2;

   typedef struct packed {
      mf3_pkg::pixel_type median;
      logic               last;
   } median_item_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_valid  = 1'b0;
   logic                            req_stall;
   logic                            req_action = mf3_pkg::ACTION_PIXEL;
   mf3_pkg::pixel_type              req_pixel  = '0;
   logic                            rsp_valid;
   logic                            rsp_stall  = 1'b0;
   mf3_pkg::pixel_type              rsp_median;
   logic                            rsp_last;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [mf3_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [mf3_pkg::CSR_DATA_W-1:0]  csr_data   = '0;

   // Behavioral copy of the filter state
   logic [mf3_pkg::FRAME_WIDTH_W-1:0] width_reg  = mf3_pkg::FRAME_WIDTH_RESET;
   logic [mf3_pkg::ROW_W-1:0]         height_reg = mf3_pkg::FRAME_HEIGHT_RESET;
   mf3_pkg::pixel_type                upper_line [LINE_DEPTH];
   mf3_pkg::pixel_type                middle_line[LINE_DEPTH];
   mf3_pkg::pixel_type                win[9];
   int unsigned                       col_pos = 0;
   int unsigned                       row_pos = 0;

   median_item_type median_q[$];

   int unsigned send_gap_max    = 0;
   int unsigned recv_gap_max    = 0;
   int unsigned long_hold       = 0;
   int unsigned items_sent      = 0;
   int unsigned frames_done     = 0;
   int unsigned medians_checked = 0;
   int unsigned error_count     = 0;
   int unsigned quiet_cycles    = 0;
   int unsigned stall_cycles    = 0;

   median_filter_3x3 #(.MAX_WIDTH(LINE_DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_action(req_action),
      .req_pixel (req_pixel),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_median(rsp_median),
      .rsp_last  (rsp_last),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned active_width();
      int unsigned w;
      w = 32'(width_reg);
      if (w < mf3_pkg::MIN_SIZE) w = mf3_pkg::MIN_SIZE;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      return w;
   endfunction

   function automatic int unsigned active_height();
      int unsigned h;
      h = 32'(height_reg);
      if (h < mf3_pkg::MIN_SIZE) h = mf3_pkg::MIN_SIZE;
      if (h > mf3_pkg::MAX_HEIGHT) h = mf3_pkg::MAX_HEIGHT;
      return h;
   endfunction

   function automatic mf3_pkg::pixel_type median_of_nine(input mf3_pkg::pixel_type vals[9]);
      mf3_pkg::pixel_type s[9];
      mf3_pkg::pixel_type t;
      int                 j;
      s = vals;
      for (int i = 1; i < 9; i++) begin
         t = s[i];
         j = i - 1;
         while (j >= 0 && s[j] > t) begin
            s[j + 1] = s[j];
            j--;
         end
         s[j + 1] = t;
      end
      return s[4];
   endfunction

   // Advances the filter by one accepted item and queues the median it completes.
   function automatic void filter_step(input logic action, input mf3_pkg::pixel_type pix);
      int unsigned        w, h, c, r;
      int                 cr, cc, nr, nc;
      mf3_pkg::pixel_type v, above, top;
      mf3_pkg::pixel_type hood[9];
      logic               emit, at_end;
      median_item_type    item;
      w = active_width();
      h = active_height();
      c = col_pos;
      r = row_pos;
      if (action == mf3_pkg::ACTION_FLUSH && r == 0 && c == 0) return;
      // flushes and anything past the last row are zero padding
      v = (action == mf3_pkg::ACTION_FLUSH || r >= h) ? '0 : pix;
      above = middle_line[c];
      top   = upper_line[c];
      upper_line[c]  = above;
      middle_line[c] = v;
      for (int i = 0; i < 3; i++) begin
         win[i * 3]     = win[i * 3 + 1];
         win[i * 3 + 1] = win[i * 3 + 2];
      end
      win[2] = top;
      win[5] = above;
      win[8] = v;
      emit   = (r >= 2) || (r == 1 && c >= 1);
      at_end = 1'b0;
      if (emit) begin
         // center lags one row and one column behind the incoming pixel
         if (c == 0) begin
            cr = int'(r) - 2;
            cc = int'(w) - 1;
         end else begin
            cr = int'(r) - 1;
            cc = int'(c) - 1;
         end
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               nr = cr - 1 + i;
               nc = cc - 1 + k;
               hood[i * 3 + k] = (nr >= 0 && nr < int'(h) && nc >= 0 && nc < int'(w)) ?
                                 win[i * 3 + k] : '0;
            end
         end
         at_end      = (cr == int'(h) - 1) && (cc == int'(w) - 1);
         item.median = median_of_nine(hood);
         item.last   = at_end;
         median_q.push_back(item);
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      col_pos = c;
      row_pos = r & 'h1FFF;
      if (at_end) begin
         col_pos = 0;
         row_pos = 0;
      end
   endfunction

   function automatic mf3_pkg::pixel_type draw_pixel();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return mf3_pkg::pixel_type'($urandom_range(0, 255));
      endcase
   endfunction

   // valid stays up after a transfer; the next call either lowers it or replaces the payload
   task automatic send_item(input logic action, input mf3_pkg::pixel_type pix);
      int unsigned gap;
      gap = $urandom_range(0, send_gap_max);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= action;
      req_pixel  <= pix;
      do @(posedge clock); while (req_stall);
      filter_step(action, pix);
      items_sent++;
   endtask

   task automatic wait_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (median_q.size() != 0) @(posedge clock);
   endtask

   // Frame items with no result may still be in flight after the last median
   task automatic drain_idle();
      wait_results();
      repeat (LATENCY_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mf3_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [mf3_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == mf3_pkg::CSR_FRAME_WIDTH || idx == mf3_pkg::CSR_FRAME_HEIGHT) begin
         if (idx == mf3_pkg::CSR_FRAME_WIDTH) width_reg = data[mf3_pkg::FRAME_WIDTH_W-1:0];
         else height_reg = data;
         col_pos = 0;
         row_pos = 0;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h);
      drain_idle();
      write_reg(mf3_pkg::CSR_FRAME_WIDTH, mf3_pkg::CSR_DATA_W'(w));
      write_reg(mf3_pkg::CSR_FRAME_HEIGHT, mf3_pkg::CSR_DATA_W'(h));
   endtask

   task automatic stream_pixels(input int unsigned count, input int unsigned flush_pct);
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < flush_pct) send_item(mf3_pkg::ACTION_FLUSH, draw_pixel());
         else send_item(mf3_pkg::ACTION_PIXEL, draw_pixel());
      end
   endtask

   // width+1 items close the frame; when mixed, some are pixels that count as padding
   task automatic stream_tail(input bit mixed, input int unsigned extra);
      int unsigned n;
      n = active_width() + 1;
      for (int unsigned i = 0; i < n; i++)
         send_item((mixed && $urandom_range(0, 1) == 1) ? mf3_pkg::ACTION_PIXEL :
                                                          mf3_pkg::ACTION_FLUSH,
                   draw_pixel());
      repeat (extra) send_item(mf3_pkg::ACTION_FLUSH, draw_pixel());
   endtask

   task automatic send_frame(input int unsigned flush_pct, input bit mixed_tail,
                             input int unsigned extra);
      stream_pixels(active_width() * active_height(), flush_pct);
      stream_tail(mixed_tail, extra);
      frames_done++;
   endtask

   task automatic test_reset_geometry();
      send_gap_max = 0;
      recv_gap_max = MAX_GAP;
      repeat (3) send_item(mf3_pkg::ACTION_FLUSH, draw_pixel());
      // part of a row at the reset width, so no center completes; dropped later
      stream_pixels(20, 0);
      drain_idle();
   endtask

   task automatic test_directed();
      mf3_pkg::pixel_type ramp[9];
      ramp = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hFE, 8'h7F, 8'h55, 8'hAA, 8'hFF};
      set_geometry(3, 3);
      send_gap_max = MAX_GAP;
      recv_gap_max = MAX_GAP;
      foreach (ramp[i]) send_item(mf3_pkg::ACTION_PIXEL, ramp[i]);
      stream_tail(1'b0, 2);
      // white frame with a flush at the center, closed by pixel items
      for (int i = 0; i < 9; i++)
         send_item((i == 4) ? mf3_pkg::ACTION_FLUSH : mf3_pkg::ACTION_PIXEL, 8'hFF);
      for (int i = 0; i < 4; i++) send_item(mf3_pkg::ACTION_PIXEL, 8'hFF);
      frames_done += 2;
   endtask

   task automatic test_size_limits();
      send_gap_max = 0;
      recv_gap_max = 0;
      set_geometry(0, 0);
      send_frame(0, 1'b0, 0);
      // oversized width clamps to the line length; part of a row, then dropped
      set_geometry(32'h1FFF, 2);
      stream_pixels(30, 2);
      // narrow and very tall: only rows far from the bottom edge
      set_geometry(1, 32'h1FFF);
      stream_pixels(30, 2);
      // a write to an unused index must not restart the frame
      set_geometry(5, 4);
      send_gap_max = MAX_GAP;
      recv_gap_max = MAX_GAP;
      stream_pixels(12, 0);
      drain_idle();
      write_reg(CSR_SPARE_INDEX, 13'h1FFF);
      stream_pixels(8, 0);
      stream_tail(1'b1, 0);
      frames_done++;
      // abandoned frame; the register writes start a fresh one
      set_geometry(6, 5);
      stream_pixels(17, 5);
      set_geometry(4, 3);
      send_frame(5, 1'b1, 1);
   endtask

   task automatic test_backpressure();
      set_geometry(10, 6);
      send_gap_max = 0;
      recv_gap_max = 0;
      long_hold    = LONG_HOLD;
      stream_pixels(40, 0);
      wait_results();
      send_gap_max = MAX_GAP;
      recv_gap_max = MAX_GAP;
      stream_pixels(20, 5);
      stream_tail(1'b1, 0);
      frames_done++;
   endtask

   task automatic test_random_frames();
      int unsigned start_count, w, h;
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         w = $urandom_range(3, 12);
         h = $urandom_range(3, 8);
         set_geometry(w, h);
         send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
         recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
         if ($urandom_range(0, 5) == 0) begin
            stream_pixels($urandom_range(1, w * h - 1), 10);
         end else begin
            repeat ($urandom_range(1, 2)) begin
               repeat ($urandom_range(0, 2)) send_item(mf3_pkg::ACTION_FLUSH, draw_pixel());
               send_frame(5, 1'b1, $urandom_range(0, 2));
            end
         end
      end
   endtask

   initial begin : result_sink
      int unsigned hold;
      @(negedge clock);
      forever begin
         if (long_hold != 0) begin
            hold      = long_hold;
            long_hold = 0;
         end else begin
            hold = $urandom_range(0, recv_gap_max);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : check_results
      median_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (median_q.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: unexpected result median %0d last %0b",
                        $time, rsp_median, rsp_last);
         end else begin
            want = median_q.pop_front();
            medians_checked++;
            if (rsp_median !== want.median || rsp_last !== want.last) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: result %0d expected %0d/%0b, got %0d/%0b (median/last)",
                           $time, medians_checked, want.median, want.last,
                           rsp_median, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (req_valid && req_stall) stall_cycles <= stall_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles, %0d results pending",
                  quiet_cycles, median_q.size());
         $display("tb_median_filter_3x3: done, errors");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_geometry();
      test_directed();
      test_size_limits();
      test_backpressure();
      test_random_frames();
      drain_idle();
      $display("run covered %0d items in %0d frames, %0d medians checked, %0d stall cycles",
               items_sent, frames_done, medians_checked, stall_cycles);
      $display("frames 3x3 to 12x8, clamped sizes, unused register index, dropped frames");
      if (error_count == 0)
         $display("tb_median_filter_3x3: done, clean");
      else
         $display("tb_median_filter_3x3: done, errors");
      $finish;
   end

endmodule
